/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands, sampled on clk and held off while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PBPS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pbps_pkg.sv */
// ----------------------------------------------------------------------------
// pbps_pkg
// shared types, codes and the beep pattern table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbps_pkg;

  localparam int NUM_PATTERNS = 15;
  localparam int MAX_STEPS    = 6;
  localparam int DUR_W        = 10;

  localparam logic [DUR_W-1:0] ELAPSED_MAX = 10'd1023;
  localparam logic [3:0]       PAT_INVALID = 4'd15;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_ENQUEUE = 2'd1,
    CMD_PLAY    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  // one pending request
  typedef struct packed {
    logic [3:0] pat;
    logic [1:0] pri;
    logic       frc;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_SHIFT = 2'd2
  } cell_op_t;

  typedef enum logic [2:0] {
    Q_NONE       = 3'd0,
    Q_POP        = 3'd1,
    Q_PUSH       = 3'd2,
    Q_CLEAR      = 3'd3,
    Q_SCAN_START = 3'd4,
    Q_SCAN_STEP  = 3'd5,
    Q_EVICT      = 3'd6
  } q_op_t;

  typedef struct packed {
    entry_t     head;
    logic       empty;
    logic       full;
    logic       scan_last;
    logic [1:0] run_min;
  } q_stat_t;

  // step durations in ms, zero marks the end of a pattern
  localparam logic [DUR_W-1:0] DUR_TBL [NUM_PATTERNS][MAX_STEPS] = '{
    '{10'd15,  10'd0,   10'd0,   10'd0,   10'd0,   10'd0},
    '{10'd30,  10'd0,   10'd0,   10'd0,   10'd0,   10'd0},
    '{10'd60,  10'd40,  10'd30,  10'd0,   10'd0,   10'd0},
    '{10'd40,  10'd40,  10'd80,  10'd0,   10'd0,   10'd0},
    '{10'd20,  10'd0,   10'd0,   10'd0,   10'd0,   10'd0},
    '{10'd30,  10'd40,  10'd30,  10'd0,   10'd0,   10'd0},
    '{10'd150, 10'd0,   10'd0,   10'd0,   10'd0,   10'd0},
    '{10'd100, 10'd50,  10'd100, 10'd50,  10'd200, 10'd0},
    '{10'd150, 10'd100, 10'd150, 10'd100, 10'd150, 10'd0},
    '{10'd100, 10'd0,   10'd0,   10'd0,   10'd0,   10'd0},
    '{10'd400, 10'd100, 10'd400, 10'd100, 10'd800, 10'd0},
    '{10'd150, 10'd60,  10'd300, 10'd0,   10'd0,   10'd0},
    '{10'd600, 10'd0,   10'd0,   10'd0,   10'd0,   10'd0},
    '{10'd40,  10'd0,   10'd0,   10'd0,   10'd0,   10'd0},
    '{10'd200, 10'd100, 10'd200, 10'd0,   10'd0,   10'd0}
  };

  function automatic logic [DUR_W-1:0] rom_dur(input logic [3:0] pat,
                                               input logic [2:0] step);
    logic [DUR_W-1:0] d;
    d = '0;
    if (pat < 4'(NUM_PATTERNS) && step < 3'(MAX_STEPS)) begin
      d = DUR_TBL[pat][step];
    end
    return d;
  endfunction

  // even steps sound, odd steps are gaps, the terminator is silent
  function automatic logic rom_on(input logic [3:0] pat, input logic [2:0] step);
    return !step[0] && (rom_dur(pat, step) != '0);
  endfunction

endpackage

/* hw/rtl/priority_beep_pattern_sequencer_top.sv */
// ----------------------------------------------------------------------------
// priority_beep_pattern_sequencer_top
// prioritized beep request queue feeding a millisecond pattern player
// ----------------------------------------------------------------------------
// flow: the request is captured on its transfer, executed, then handed to
//   the output register; an enqueue into a full queue adds a priority scan
//   over the cell row, one slot per cycle; the request channel stalls until
//   the result has been handed on
// reset: synchronous rst empties the queue, stops playback, drops any result
`timescale 1ns / 1ps

module priority_beep_pattern_sequencer_top import pbps_pkg::*; #(
  parameter int QUEUE_DEPTH = 8,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  // request channel
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    cmd,
  input  logic [3:0]    pattern_id,
  input  logic [1:0]    priority_req,
  input  logic          force_req,
  input  logic          sound_enabled,
  // result channel
  output logic          out_valid,
  input  logic          out_stall,
  output logic          buzzer_on,
  output logic          busy_res,
  output logic [CW-1:0] queue_count,
  output logic          dropped
);

  // one-hot control sequence
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,  // tick / clear / push / start of eviction scan
    S_SCAN  = 5'b00100,  // walk the cells for the oldest lowest priority
    S_EVICT = 5'b01000,  // evict and append, or drop
    S_DONE  = 5'b10000   // hand the result to the output register
  } state_t;

  state_t state, state_next;

  // captured request
  cmd_t       cmd_q;
  logic [3:0] pat_q;
  logic [1:0] pri_q;
  logic       frc_q;
  logic       en_q;

  // player state
  logic             playing, playing_next;
  logic [3:0]       play_pattern, play_pattern_next;
  logic [2:0]       step_number, step_number_next;
  logic             play_force, play_force_next;
  logic [1:0]       play_priority, play_priority_next;
  logic [DUR_W-1:0] step_elapsed, step_elapsed_next;
  logic             buzzer_level, buzzer_level_next;
  logic             drop_flag, drop_flag_next;

  // queue interface
  q_op_t         q_op;
  q_stat_t       q_stat;
  logic [CW-1:0] q_count;
  entry_t        new_entry;

  logic             stop;
  logic [DUR_W-1:0] elapsed_inc;
  logic [DUR_W-1:0] cur_dur;
  logic [DUR_W-1:0] nxt_dur;
  logic [DUR_W-1:0] head_dur;
  logic             out_load;
  logic             in_take;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  assign new_entry = '{pat: pat_q, pri: pri_q, frc: frc_q};

  pbps_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .op        (q_op),
    .new_entry (new_entry),
    .count     (q_count),
    .stat      (q_stat)
  );

  // table lookups for the current step, the one after it, and a fresh start
  assign cur_dur     = rom_dur(play_pattern, step_number);
  assign nxt_dur     = rom_dur(play_pattern, step_number + 3'd1);
  assign head_dur    = rom_dur(q_stat.head.pat, 3'd0);
  // elapsed time saturates so that a very long step cannot wrap
  assign elapsed_inc = (step_elapsed == ELAPSED_MAX) ? step_elapsed
                                                      : step_elapsed + 10'd1;

  always_comb begin
    state_next         = state;
    q_op               = Q_NONE;
    stop               = 1'b0;
    playing_next       = playing;
    play_pattern_next  = play_pattern;
    step_number_next   = step_number;
    play_force_next    = play_force;
    play_priority_next = play_priority;
    step_elapsed_next  = step_elapsed;
    buzzer_level_next  = buzzer_level;
    drop_flag_next     = drop_flag;

    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end

      S_EXEC: begin
        drop_flag_next = 1'b0;
        state_next     = S_DONE;
        case (cmd_q)
          CMD_TICK: begin
            if (!playing) begin
              if (!q_stat.empty) begin
                // start the oldest pending request
                q_op               = Q_POP;
                playing_next       = 1'b1;
                play_pattern_next  = q_stat.head.pat;
                play_force_next    = q_stat.head.frc;
                play_priority_next = q_stat.head.pri;
                step_number_next   = 3'd0;
                step_elapsed_next  = '0;
                buzzer_level_next  = rom_on(q_stat.head.pat, 3'd0);
                if (head_dur == '0) stop = 1'b1;
                // sound disabled silences an unforced pattern at once
                if (!q_stat.head.frc && !en_q) stop = 1'b1;
              end else begin
                buzzer_level_next = 1'b0;
              end
            end else begin
              step_elapsed_next = elapsed_inc;
              if (!play_force && !en_q) begin
                stop = 1'b1;
              end else if (cur_dur == '0) begin
                stop = 1'b1;
              end else if (elapsed_inc >= cur_dur) begin
                // step done: advance, end of pattern on the terminator
                step_number_next  = step_number + 3'd1;
                step_elapsed_next = '0;
                if (nxt_dur == '0) stop = 1'b1;
                else buzzer_level_next = rom_on(play_pattern, step_number + 3'd1);
              end
            end
          end

          CMD_CLEAR: begin
            // queue only, a playing pattern goes on
            q_op = Q_CLEAR;
          end

          CMD_ENQUEUE, CMD_PLAY: begin
            if (pat_q != PAT_INVALID) begin
              // play immediate preempts an equal or lower priority pattern
              if (cmd_q == CMD_PLAY && playing && pri_q >= play_priority) begin
                stop = 1'b1;
              end
              if (q_stat.full) begin
                q_op       = Q_SCAN_START;
                state_next = S_SCAN;
              end else begin
                q_op = Q_PUSH;
              end
            end
          end

          default: ;
        endcase
      end

      S_SCAN: begin
        q_op = Q_SCAN_STEP;
        if (q_stat.scan_last) state_next = S_EVICT;
      end

      S_EVICT: begin
        // only evict an entry whose priority does not exceed the newcomer
        if (q_stat.run_min > pri_q) drop_flag_next = 1'b1;
        else q_op = Q_EVICT;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase

    if (stop) begin
      buzzer_level_next  = 1'b0;
      playing_next       = 1'b0;
      play_pattern_next  = 4'd0;
      step_number_next   = 3'd0;
      play_force_next    = 1'b0;
      play_priority_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      playing       <= 1'b0;
      play_pattern  <= 4'd0;
      step_number   <= 3'd0;
      play_force    <= 1'b0;
      play_priority <= 2'd0;
      step_elapsed  <= '0;
      buzzer_level  <= 1'b0;
      drop_flag     <= 1'b0;
    end else begin
      state         <= state_next;
      playing       <= playing_next;
      play_pattern  <= play_pattern_next;
      step_number   <= step_number_next;
      play_force    <= play_force_next;
      play_priority <= play_priority_next;
      step_elapsed  <= step_elapsed_next;
      buzzer_level  <= buzzer_level_next;
      drop_flag     <= drop_flag_next;
    end
  end

  // capture the request on its transfer
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q <= cmd_t'(cmd);
      pat_q <= pattern_id;
      pri_q <= priority_req;
      frc_q <= force_req;
      en_q  <= sound_enabled;
    end
  end

  // output register: a waiting result does not hold up new requests
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      buzzer_on   <= buzzer_level;
      busy_res    <= playing || (q_count != '0);
      queue_count <= q_count;
      dropped     <= drop_flag;
    end
  end

endmodule

/* hw/rtl/pbps_cell.sv */
// ----------------------------------------------------------------------------
// pbps_cell
// one queue slot: holds, loads a new request or takes its neighbor's entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbps_cell import pbps_pkg::*; (
  input  logic     clk,
  input  cell_op_t op,
  input  entry_t   load_entry,
  input  entry_t   next_entry,
  output entry_t   entry
);

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD:  entry <= load_entry;
      CELL_SHIFT: entry <= next_entry;
      default:    entry <= entry;
    endcase
  end

endmodule

/* hw/rtl/pbps_queue.sv */
// ----------------------------------------------------------------------------
// pbps_queue
// row of request cells ordered oldest first, with fill count and
// lowest-priority scan for eviction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbps_queue import pbps_pkg::*; #(
  parameter int QUEUE_DEPTH = 8,
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int KW = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  q_op_t         op,
  input  entry_t        new_entry,
  output logic [CW-1:0] count,
  output q_stat_t       stat
);

  entry_t        cells [QUEUE_DEPTH];
  logic [CW-1:0] cnt;
  logic [KW-1:0] scan_k;
  logic [KW-1:0] min_off;
  logic [1:0]    run_min;
  entry_t        scan_entry;

  assign scan_entry = cells[scan_k];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t   next_entry;
    cell_op_t cop;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_entry = new_entry;
    end else begin : g_mid
      assign next_entry = cells[i+1];
    end

    always_comb begin
      cop = CELL_HOLD;
      case (op)
        Q_POP: cop = CELL_SHIFT;
        Q_PUSH: begin
          if (cnt == CW'(i)) cop = CELL_LOAD;
        end
        Q_EVICT: begin
          // entries behind the evicted one move up, new request at the back
          if (i == QUEUE_DEPTH - 1) cop = CELL_LOAD;
          else if (KW'(i) >= min_off) cop = CELL_SHIFT;
        end
        default: cop = CELL_HOLD;
      endcase
    end

    pbps_cell u_cell (
      .clk        (clk),
      .op         (cop),
      .load_entry (new_entry),
      .next_entry (next_entry),
      .entry      (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (op)
        Q_POP:   cnt <= cnt - CW'(1);
        Q_PUSH:  cnt <= cnt + CW'(1);
        Q_CLEAR: cnt <= '0;
        default: cnt <= cnt;
      endcase
    end
  end

  // first (oldest) minimum wins: strict less-than
  always_ff @(posedge clk) begin
    case (op)
      Q_SCAN_START: begin
        scan_k  <= KW'(1);
        run_min <= cells[0].pri;
        min_off <= '0;
      end
      Q_SCAN_STEP: begin
        scan_k <= scan_k + KW'(1);
        if (scan_entry.pri < run_min) begin
          run_min <= scan_entry.pri;
          min_off <= scan_k;
        end
      end
      default: ;
    endcase
  end

  assign count          = cnt;
  assign stat.head      = cells[0];
  assign stat.empty     = (cnt == '0);
  assign stat.full      = (cnt == CW'(QUEUE_DEPTH));
  assign stat.scan_last = (scan_k == KW'(QUEUE_DEPTH - 1));
  assign stat.run_min   = run_min;

endmodule

/* hw/rtl/pbps_checker.sv */
// ----------------------------------------------------------------------------
// pbps_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pbps_checker #(
  parameter int QUEUE_DEPTH = 8,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_stall,
  input logic          buzzer_on,
  input logic          busy_res,
  input logic [CW-1:0] queue_count,
  input logic          dropped
);

  `PBPS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `PBPS_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(queue_count) && $stable(dropped) && $stable(buzzer_on) && $stable(busy_res), "stalled result changed")
  `PBPS_ASSERT(a_count_max, out_valid, queue_count <= CW'(QUEUE_DEPTH), "queue count above depth")
  `PBPS_ASSERT(a_busy_pending, out_valid && queue_count != '0, busy_res, "pending requests but not busy")
  `PBPS_ASSERT(a_drop_full, out_valid && dropped, queue_count == CW'(QUEUE_DEPTH), "drop with room in queue")

endmodule

bind priority_beep_pattern_sequencer_top pbps_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_pbps_checker (.*);
